[src/assert_macros.svh]
// assertion helpers shared by the checker
// both sample on clock and are disabled while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle
`define SSE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sparse set check failed");

// consequent checked in the next cycle
`define SSE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sparse set check failed");

`endif

[src/sse_pkg.sv]
`timescale 1ns / 1ps
package sse_pkg;

   localparam int CAPACITY = 256;
   localparam int ID_RANGE = 1024;
   localparam int CAP_W    = $clog2(CAPACITY);
   localparam int ID_W     = $clog2(ID_RANGE);
   localparam int CNT_W    = CAP_W + 1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BAD_ID  = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;
   localparam logic [1:0] STATUS_ABSENT  = 2'd3;

   localparam logic FUNC_ADD    = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   typedef struct packed {
      logic            func;
      logic [ID_W-1:0] id;
   } req_type;

   typedef struct packed {
      logic [CAP_W-1:0] slot;
      logic [1:0]       status;
      logic [CNT_W-1:0] count;
   } rsp_type;

   // write port of the slot table
   typedef struct packed {
      logic             en;
      logic [ID_W-1:0]  addr;
      logic [CAP_W-1:0] data;
   } tbl_wr_type;

   // write port of the member list
   typedef struct packed {
      logic             en;
      logic [CAP_W-1:0] addr;
      logic [ID_W-1:0]  data;
   } lst_wr_type;

   // both read ports of the member list
   typedef struct packed {
      logic             en;
      logic [CAP_W-1:0] addr_a;
      logic [CAP_W-1:0] addr_b;
   } lst_rd_type;

endpackage

[src/sse_slot_table.sv]
`timescale 1ns / 1ps
module sse_slot_table (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [sse_pkg::ID_W-1:0] rd_addr,
   input  sse_pkg::tbl_wr_type      wr,
   output logic [sse_pkg::CAP_W-1:0] rd_data
);
   import sse_pkg::*;

   logic [CAP_W-1:0] mem_ff [ID_RANGE];
   logic [CAP_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   // new data wins on a read of the entry being written
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr.en && (wr.addr == rd_addr)) begin
            rd_ff <= wr.data;
         end else begin
            rd_ff <= mem_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_ff;

endmodule

[src/sse_member_list.sv]
`timescale 1ns / 1ps
module sse_member_list (
   input  logic                     clock,
   input  sse_pkg::lst_rd_type      rd,
   input  sse_pkg::lst_wr_type      wr,
   output logic [sse_pkg::ID_W-1:0] rd_data_a,
   output logic [sse_pkg::ID_W-1:0] rd_data_b
);
   import sse_pkg::*;

   logic [ID_W-1:0] mem_ff [CAPACITY];
   logic [ID_W-1:0] rd_a_ff;
   logic [ID_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   // reads and writes never fall in the same cycle here
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_a_ff <= mem_ff[rd.addr_a];
         rd_b_ff <= mem_ff[rd.addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[src/sparse_set_engine_top.sv]
// sparse set engine: packed member list plus slot-of-id table, both in sync ram
// flow: a taken request beat reads the slot table, ST_LOOK issues the list reads
//   and ST_CHECK, once the result register is free, registers the result beat
//   and takes the next beat (one item's table write overlaps the next item's table read)
// reset: synchronous; count cleared, then a pass over all 1024 entries zeroes the
//   slot table while req_stall stays high
`timescale 1ns / 1ps
module sparse_set_engine_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sse_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sse_pkg::rsp_type rsp_payload
);
   import sse_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,   // zeroing the slot table
      ST_IDLE  = 4'b0010,   // waiting for a request beat
      ST_LOOK  = 4'b0100,   // slot table data back, list reads issued
      ST_CHECK = 4'b1000    // list data back, decide and write back
   } state_type;

   state_type        state_ff, state_in;
   logic [ID_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [CNT_W-1:0] count_ff, count_in;
   req_type          op_ff, op_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             out_free;
   logic             req_accept;
   logic             fire;
   logic             bad_id;
   logic             full;
   logic             present;
   logic [CAP_W-1:0] pos;
   logic [ID_W-1:0]  list_at_pos;
   logic [ID_W-1:0]  list_tail;
   logic [CNT_W-1:0] tail_idx;
   tbl_wr_type       tbl_wr;
   lst_wr_type       lst_wr;
   lst_rd_type       lst_rd;

   // memories
   sse_slot_table u_slot_table (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (req_payload.id),
      .wr      (tbl_wr),
      .rd_data (pos)
   );

   sse_member_list u_member_list (
      .clock     (clock),
      .rd        (lst_rd),
      .wr        (lst_wr),
      .rd_data_a (list_at_pos),
      .rd_data_b (list_tail)
   );

   // handshake: result register frees up when empty or being taken
   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      req_stall  = !((state_ff == ST_IDLE) || ((state_ff == ST_CHECK) && out_free));
      req_accept = req_valid && !req_stall;
      fire       = (state_ff == ST_CHECK) && out_free;
   end

   // list reads: slot named by the table, and the current tail
   always_comb begin
      tail_idx      = count_ff - CNT_W'(1);
      lst_rd.en     = (state_ff == ST_LOOK);
      lst_rd.addr_a = pos;
      lst_rd.addr_b = tail_idx[CAP_W-1:0];
   end

   // decision for the item in ST_CHECK
   always_comb begin
      bad_id  = (op_ff.id == '0);
      full    = (count_ff == CNT_W'(CAPACITY));
      present = ({1'b0, pos} < count_ff) && (list_at_pos == op_ff.id);

      count_in    = count_ff;
      tbl_wr      = '0;
      lst_wr      = '0;
      rsp_in      = rsp_ff;
      clr_cnt_in  = clr_cnt_ff;
      state_in    = state_ff;
      op_in       = op_ff;

      if (req_accept) begin
         op_in = req_payload;
      end

      case (state_ff)
         ST_CLEAR: begin
            tbl_wr.en   = 1'b1;
            tbl_wr.addr = clr_cnt_ff;
            tbl_wr.data = '0;
            clr_cnt_in  = clr_cnt_ff + ID_W'(1);
            if (clr_cnt_ff == ID_W'(ID_RANGE - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (fire) begin
               rsp_in.slot   = '0;
               rsp_in.status = STATUS_OK;
               if (bad_id) begin
                  rsp_in.status = STATUS_BAD_ID;
               end else if (op_ff.func == FUNC_ADD) begin
                  if (full) begin
                     rsp_in.status = STATUS_FULL;
                  end else begin
                     // append at the tail
                     lst_wr.en     = 1'b1;
                     lst_wr.addr   = count_ff[CAP_W-1:0];
                     lst_wr.data   = op_ff.id;
                     tbl_wr.en     = 1'b1;
                     tbl_wr.addr   = op_ff.id;
                     tbl_wr.data   = count_ff[CAP_W-1:0];
                     rsp_in.slot   = count_ff[CAP_W-1:0];
                     count_in      = count_ff + CNT_W'(1);
                  end
               end else begin
                  if (!present) begin
                     rsp_in.status = STATUS_ABSENT;
                  end else begin
                     // move the tail member into the freed slot
                     lst_wr.en     = 1'b1;
                     lst_wr.addr   = pos;
                     lst_wr.data   = list_tail;
                     tbl_wr.en     = 1'b1;
                     tbl_wr.addr   = list_tail;
                     tbl_wr.data   = pos;
                     rsp_in.slot   = pos;
                     count_in      = count_ff - CNT_W'(1);
                  end
               end
               rsp_in.count = count_in;
               state_in     = req_accept ? ST_LOOK : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[src/sse_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sse_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input sse_pkg::req_type req_payload,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input sse_pkg::rsp_type rsp_payload
);
   import sse_pkg::*;

   logic req_beat;
   assign req_beat = req_valid && !req_stall;

   // a stalled result beat holds
   `SSE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

   // two request beats never land on adjacent edges
   `SSE_ASSERT_NEXT(a_req_spacing, req_beat, !req_beat)

   // error results carry slot zero
   `SSE_ASSERT_NOW(a_err_slot, rsp_valid && (rsp_payload.status != STATUS_OK), rsp_payload.slot == '0)

   // a full report only comes with the list at capacity
   `SSE_ASSERT_NOW(a_full_count, rsp_valid && (rsp_payload.status == STATUS_FULL), rsp_payload.count == CNT_W'(CAPACITY))

endmodule

bind sparse_set_engine_top sse_checker u_sse_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

[test/sparse_set_checker.sv]
`timescale 1ns / 1ps
module sparse_set_checker
   import sse_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_payload,
   output int      fail_count,
   output int      pending
);

   logic [CNT_W-1:0] member_total;
   logic [ID_W-1:0]  member_ids [CAPACITY];
   logic [CAP_W-1:0] slot_by_id [ID_RANGE];
   rsp_type          awaited_rsps [$];
   int               mismatches = 0;
   int               results_open = 0;

   assign fail_count = mismatches;
   assign pending    = results_open;

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // applies one request to the shadow set and returns the result beat it causes
   function automatic rsp_type predict_set_op(input req_type beat);
      rsp_type          res;
      logic [CAP_W-1:0] pos;
      logic [ID_W-1:0]  tail_id;
      logic [CNT_W-1:0] last_idx;
      res.slot   = '0;
      res.status = STATUS_OK;
      if (beat.id == '0) begin
         res.status = STATUS_BAD_ID;
      end else if (beat.func == FUNC_ADD) begin
         if (member_total >= CNT_W'(CAPACITY)) begin
            res.status = STATUS_FULL;
         end else begin
            res.slot               = member_total[CAP_W-1:0];
            member_ids[res.slot]   = beat.id;
            slot_by_id[beat.id]    = res.slot;
            member_total           = member_total + 1'b1;
         end
      end else begin
         pos = slot_by_id[beat.id];
         if (CNT_W'(pos) >= member_total || member_ids[pos] != beat.id) begin
            res.status = STATUS_ABSENT;
         end else begin
            // last member fills the freed slot
            last_idx            = member_total - 1'b1;
            tail_id             = member_ids[last_idx[CAP_W-1:0]];
            member_ids[pos]     = tail_id;
            slot_by_id[tail_id] = pos;
            member_total        = member_total - 1'b1;
            res.slot            = pos;
         end
      end
      res.count = member_total;
      return res;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         member_total = '0;
         for (int i = 0; i < CAPACITY; i++) member_ids[i] = '0;
         for (int i = 0; i < ID_RANGE; i++) slot_by_id[i] = '0;
         awaited_rsps.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsps.size() == 0) begin
               flag_mismatch("result beat with nothing pending", 0, 0);
            end else begin
               want = awaited_rsps.pop_front();
               if (rsp_payload.slot !== want.slot)
                  flag_mismatch("slot", int'(rsp_payload.slot), int'(want.slot));
               if (rsp_payload.status !== want.status)
                  flag_mismatch("status", int'(rsp_payload.status), int'(want.status));
               if (rsp_payload.count !== want.count)
                  flag_mismatch("count", int'(rsp_payload.count), int'(want.count));
            end
         end
         if (req_valid && !req_stall)
            awaited_rsps.push_back(predict_set_op(req_payload));
      end
      results_open <= awaited_rsps.size();
   end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
module tb;
   import sse_pkg::*;

   // cycles with no beat on either channel before the run is declared hung;
   // covers the slot table clear after reset and the longest result hold-off
   localparam int QUIET_LIMIT = 6000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;
   int      fail_count;
   int      pending;

   // ids the stimulus believes are members, used to aim removes at present ids
   int      member_pool [$];
   // items left in the current run of back-to-back request beats
   int      burst_left = 0;

   sparse_set_engine_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   sparse_set_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // idle length between request beats: mostly none or short, now and then long
   function automatic int idle_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // offers one request beat and holds it until taken, then maybe idles;
   // valid stays high into the next beat when there is no gap
   task automatic send_item(input logic func, input logic [ID_W-1:0] id);
      req_type beat;
      int      gap;
      beat.func    = func;
      beat.id      = id;
      req_payload <= beat;
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall);
      // keep the pool roughly in line with what the block holds
      if (func == FUNC_ADD && id != '0 && member_pool.size() < 400)
         member_pool.push_back(id);
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else begin
         if ($urandom_range(0, 49) == 0) burst_left = 30;
         gap = idle_gap();
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender stops until every expected result beat has come back
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // random requests; add_pct sets the add/remove mix so a phase fills or drains
   task automatic run_phase(input int items, input int add_pct);
      int          roll;
      int          idx;
      logic        func;
      logic [ID_W-1:0] id;
      repeat (items) begin
         if ($urandom_range(0, 99) < 2) wait_results_drained();
         roll = $urandom_range(0, 99);
         if (roll < add_pct) begin
            func = FUNC_ADD;
            roll = $urandom_range(0, 99);
            if (roll < 4) id = '0;
            // small ids so repeated adds of one id are common
            else if (roll < 20) id = ID_W'($urandom_range(1, 8));
            else id = ID_W'($urandom_range(1, ID_RANGE - 1));
         end else begin
            func = FUNC_REMOVE;
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
               id = '0;
            end else if (roll < 14 || member_pool.size() == 0) begin
               id = ID_W'($urandom_range(0, ID_RANGE - 1));
            end else begin
               // aim at an id that was added earlier
               idx = $urandom_range(0, member_pool.size() - 1);
               id  = ID_W'(member_pool[idx]);
               member_pool.delete(idx);
            end
         end
         send_item(func, id);
      end
   endtask

   // result side: quiet stretches, random stalls and long hold-offs; one long
   // hold-off is forced once enough cycles have passed so the input backs up
   initial begin : rsp_side
      int seg_len;
      int hold_len;
      int roll;
      int cycles_seen;
      bit forced_done;
      bit quiet;
      cycles_seen = 0;
      forced_done = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         roll = $urandom_range(0, 99);
         if (!forced_done && cycles_seen >= 2000) begin
            forced_done = 1'b1;
            hold_len    = 150;
         end else if (roll < 3) begin
            hold_len = $urandom_range(60, 150);
         end else begin
            hold_len = 0;
         end
         if (hold_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_len) @(posedge clock);
            cycles_seen += hold_len;
         end else begin
            seg_len = $urandom_range(10, 50);
            quiet   = (roll < 40);
            repeat (seg_len) begin
               if (quiet) rsp_stall <= 1'b0;
               else rsp_stall <= ($urandom_range(0, 99) < 40);
               @(posedge clock);
            end
            cycles_seen += seg_len;
         end
      end
   end

   // hang detector: counts cycles in which neither channel moves a beat
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      send_item(FUNC_REMOVE, 10'd5);     // remove from an empty set
      send_item(FUNC_ADD,    10'd0);     // id zero on add
      send_item(FUNC_REMOVE, 10'd0);     // id zero on remove
      send_item(FUNC_ADD,    10'd1023);  // highest id
      send_item(FUNC_ADD,    10'd1);
      send_item(FUNC_ADD,    10'd512);
      send_item(FUNC_REMOVE, 10'd1);     // middle member, tail moves down
      send_item(FUNC_REMOVE, 10'd1);     // already gone
      send_item(FUNC_REMOVE, 10'd512);
      send_item(FUNC_REMOVE, 10'd1023);  // last member, set empties
      send_item(FUNC_REMOVE, 10'd1023);  // absent on empty set
      send_item(FUNC_ADD,    10'd7);
      send_item(FUNC_ADD,    10'd7);     // repeated add keeps a second copy
      send_item(FUNC_REMOVE, 10'd7);     // removes the newer copy
      send_item(FUNC_REMOVE, 10'd7);     // table no longer points at a member
      send_item(FUNC_ADD,    10'd682);
      send_item(FUNC_ADD,    10'd341);
      send_item(FUNC_REMOVE, 10'd682);
      send_item(FUNC_REMOVE, 10'd341);
      send_item(FUNC_REMOVE, 10'd7);     // table still points at slot 1, so the leftover 7 is reported absent
      wait_results_drained();
      member_pool.delete();

      // random part: fill past capacity, drain, mix, fill again
      run_phase(350, 92);
      wait_results_drained();
      run_phase(350, 8);
      wait_results_drained();
      run_phase(300, 50);
      run_phase(250, 80);

      // drain, then let the pipeline settle
      wait_results_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
